/* rtl/core/rrs_pkg.sv */
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the round-robin job scheduler: item payloads,
// operation and event codes, queue control flags and parameter defaults.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // parameter defaults
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TimeWidthDef  = 16;

  // quantum register after reset
  localparam logic [7:0] QuantumReset = 8'd1;

  // operation carried by an input item
  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  // what a result item reports
  typedef enum logic [2:0] {
    EV_ACCEPTED = 3'd0,
    EV_REJECTED = 3'd1,
    EV_IDLE     = 3'd2,
    EV_SERVED   = 3'd3,
    EV_DONE     = 3'd4
  } event_kind_e;

  // input item
  typedef struct packed {
    op_e        operation;
    logic [7:0] job_id;
    logic [7:0] burst_time;
  } in_item_t;

  // result item
  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  served_id;
    logic [7:0]  slice_length;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
  } out_item_t;

  // queue pointer moves requested by the slice logic
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage

/* rtl/core/rrs_ram.sv */
// ----------------------------------------------------------------------------
// rrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, read before write on a clash
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rrs_slice.sv */
// ----------------------------------------------------------------------------
// rrs_slice
// Combinational step of the scheduler: takes one item with the queue head,
// the fill count, the time and the quantum, and works out the result item,
// the queue moves, the entry to put on the tail and the new time.
// ----------------------------------------------------------------------------
module rrs_slice #(
  parameter int unsigned QueueDepth = rrs_pkg::QueueDepthDef,
  parameter int unsigned TimeWidth  = rrs_pkg::TimeWidthDef,
  localparam int unsigned CntW      = $clog2(QueueDepth + 1),
  localparam int unsigned EntryW    = 24 + TimeWidth
) (
  input  rrs_pkg::in_item_t    item_i,
  input  logic [EntryW-1:0]    head_entry_i,
  input  logic [CntW-1:0]      count_i,
  input  logic [TimeWidth-1:0] time_i,
  input  logic [7:0]           quantum_i,
  output rrs_pkg::out_item_t   result_o,
  output rrs_pkg::q_ctl_t      ctl_o,
  output logic [EntryW-1:0]    wr_entry_o,
  output logic [TimeWidth-1:0] time_o
);

  localparam logic [TimeWidth-1:0] TimeMax = '1;

  // clamp a time value to the 16-bit result fields
  function automatic logic [15:0] sat16(input logic [TimeWidth-1:0] v);
    logic [TimeWidth+15:0] ext;
    ext = {16'b0, v};
    return (ext > (TimeWidth+16)'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  logic [7:0]           e_id;
  logic [7:0]           e_burst;
  logic [7:0]           e_rem;
  logic [TimeWidth-1:0] e_arr;
  logic                 full;
  logic                 empty;
  logic [7:0]           q_eff;
  logic [7:0]           slice;
  logic [7:0]           rem_left;
  logic [7:0]           step;
  logic [TimeWidth:0]   sum;
  logic [TimeWidth-1:0] t_new;
  logic [TimeWidth-1:0] tat;
  logic [TimeWidth-1:0] wt;

  // unpack the head entry: id, burst, remaining, arrival
  assign e_arr   = head_entry_i[TimeWidth-1:0];
  assign e_rem   = head_entry_i[TimeWidth+7:TimeWidth];
  assign e_burst = head_entry_i[TimeWidth+15:TimeWidth+8];
  assign e_id    = head_entry_i[TimeWidth+23:TimeWidth+16];

  // queue occupancy
  assign full  = (count_i >= CntW'(QueueDepth));
  assign empty = (count_i == '0);

  // slice length, a zero quantum counts as one
  assign q_eff    = (quantum_i == 8'd0) ? 8'd1 : quantum_i;
  assign slice    = (e_rem < q_eff) ? e_rem : q_eff;
  assign rem_left = e_rem - slice;

  // saturating time advance
  assign step  = empty ? 8'd1 : slice;
  assign sum   = {1'b0, time_i} + (TimeWidth+1)'(step);
  assign t_new = (sum > {1'b0, TimeMax}) ? TimeMax : sum[TimeWidth-1:0];

  // completion figures, waiting floors at zero once time has saturated
  assign tat = t_new - e_arr;
  assign wt  = (tat >= TimeWidth'(e_burst)) ? tat - TimeWidth'(e_burst) : '0;

  // result and queue moves
  always_comb begin
    result_o   = '0;
    ctl_o      = '0;
    wr_entry_o = {item_i.job_id, item_i.burst_time, item_i.burst_time, time_i};
    time_o     = time_i;
    unique case (item_i.operation)
      rrs_pkg::OP_ARRIVAL: begin
        result_o.served_id = item_i.job_id;
        if (full) begin
          result_o.event_kind = rrs_pkg::EV_REJECTED;
        end else begin
          result_o.event_kind = rrs_pkg::EV_ACCEPTED;
          ctl_o.push          = 1'b1;
        end
      end
      rrs_pkg::OP_TICK: begin
        time_o = t_new;
        if (empty) begin
          result_o.event_kind = rrs_pkg::EV_IDLE;
        end else begin
          ctl_o.pop             = 1'b1;
          result_o.served_id    = e_id;
          result_o.slice_length = slice;
          if (rem_left == 8'd0) begin
            result_o.event_kind = rrs_pkg::EV_DONE;
            result_o.turnaround = sat16(tat);
            result_o.waiting    = sat16(wt);
          end else begin
            result_o.event_kind = rrs_pkg::EV_SERVED;
            ctl_o.push          = 1'b1;
            wr_entry_o          = {e_id, e_burst, rem_left, e_arr};
          end
        end
      end
      default: begin
        result_o = '0;
      end
    endcase
    result_o.finish_time = sat16(time_o);
  end

endmodule

/* rtl/core/round_robin_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_scheduler
// Round-robin job scheduler with a circular ready queue held in RAM.
// ----------------------------------------------------------------------------
// Takes one item per clock while the input is not stalled: an arrival puts a
// job on the tail of the ready queue, a tick serves the head job for up to one
// quantum and puts it back if work is left. Every item gives exactly one
// result item, which is loaded into the output register when the item is
// processed; a new item can follow every cycle while the output register is
// free or being taken. The rate is set by the queue RAM read port: each cycle
// it is read at the head as it will stand after the item in flight, and a
// write to that same slot is forwarded past the RAM. Queue slots hold no reset
// value and need no clearing after reset; the block accepts items from the
// first cycle out of reset. The user must write the quantum through the
// configuration port only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module round_robin_scheduler #(
  parameter int unsigned QueueDepth = rrs_pkg::QueueDepthDef,
  parameter int unsigned TimeWidth  = rrs_pkg::TimeWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rrs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rrs_pkg::out_item_t out_item_o
);

  localparam int unsigned IdxW   = $clog2(QueueDepth);
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);
  localparam int unsigned EntryW = 24 + TimeWidth;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);

  logic                  s_vld_q, s_vld_d;
  rrs_pkg::in_item_t     s_item_q;
  logic                  out_vld_q, out_vld_d;
  rrs_pkg::out_item_t    out_q;
  logic [7:0]            quantum_q;
  logic [IdxW-1:0]       head_q, head_d, head_inc;
  logic [IdxW-1:0]       tail_q, tail_d, tail_inc;
  logic [CntW-1:0]       count_q, count_d;
  logic [TimeWidth-1:0]  time_q, time_d;
  logic                  byp_q, byp_d;
  logic [EntryW-1:0]     byp_data_q;

  logic                  accept;
  logic                  fire;
  logic                  ram_we;
  logic [IdxW-1:0]       ram_raddr;
  logic [EntryW-1:0]     ram_rdata;
  logic [EntryW-1:0]     head_entry;
  logic [EntryW-1:0]     wr_entry;
  logic [TimeWidth-1:0]  slice_time;
  rrs_pkg::out_item_t    slice_res;
  rrs_pkg::q_ctl_t       ctl;

  // handshake: the held item moves on when the output register is empty or being taken
  assign fire       = s_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign s_vld_d   = accept || (s_vld_q && !fire);
  assign out_vld_d = fire || (out_vld_q && out_stall_i);

  // circular pointer steps
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
  assign tail_inc = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);

  // queue and time updates when the held item is processed
  assign ram_we  = fire && ctl.push;
  assign head_d  = (fire && ctl.pop) ? head_inc : head_q;
  assign tail_d  = ram_we ? tail_inc : tail_q;
  assign count_d = count_q + CntW'(ram_we) - CntW'(fire && ctl.pop);
  assign time_d  = fire ? slice_time : time_q;

  // read the head as it will stand next cycle, forward a clashing write
  assign ram_raddr  = head_d;
  assign byp_d      = ram_we && (tail_q == ram_raddr);
  assign head_entry = byp_q ? byp_data_q : ram_rdata;

  rrs_ram #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rrs_slice #(
    .QueueDepth (QueueDepth),
    .TimeWidth  (TimeWidth)
  ) u_slice (
    .item_i       (s_item_q),
    .head_entry_i (head_entry),
    .count_i      (count_q),
    .time_i       (time_q),
    .quantum_i    (quantum_q),
    .result_o     (slice_res),
    .ctl_o        (ctl),
    .wr_entry_o   (wr_entry),
    .time_o       (slice_time)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      byp_q     <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      time_q    <= '0;
      quantum_q <= rrs_pkg::QuantumReset;
    end else begin
      s_vld_q   <= s_vld_d;
      out_vld_q <= out_vld_d;
      byp_q     <= byp_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      time_q    <= time_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_item_q <= in_item_i;
    end
    if (fire) begin
      out_q <= slice_res;
    end
    byp_data_q <= wr_entry;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/core/rrs_checker.sv */
// ----------------------------------------------------------------------------
// rrs_checker
// Port-level checks of the round-robin scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rrs_pkg::out_item_t out_item_o
);

  logic        take;
  logic        seen_q;
  logic [15:0] last_ft_q;

  assign take = out_valid_o && !out_stall_i;

  // finish time of the last item taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      last_ft_q <= '0;
    end else if (take) begin
      seen_q    <= 1'b1;
      last_ft_q <= out_item_o.finish_time;
    end
  end

  // a stalled result item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed or vanished");

  // with an empty output register the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

  // time never runs backwards across delivered items
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && seen_q |-> out_item_o.finish_time >= last_ft_q)
    else $error("finish time went backwards");

  // a partial slice serves at least one unit, a finished job never waits past
  // its turnaround
  a_slice_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_item_o.event_kind != rrs_pkg::EV_SERVED || out_item_o.slice_length != 8'd0) &&
      (out_item_o.event_kind != rrs_pkg::EV_DONE ||
       out_item_o.waiting <= out_item_o.turnaround))
    else $error("inconsistent slice result");

endmodule

bind round_robin_scheduler rrs_checker u_rrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
